// ===== hw/rtl/rclfr_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the RC link frame receiver.
// Used by the parser front end, the result queue, the back end and the top level.
package rclfr_pkg;

  localparam int unsigned MaxFrameBytesDef = 64;

  localparam logic [7:0] SyncAddrARst = 8'hC8;
  localparam logic [7:0] SyncAddrBRst = 8'hEA;
  localparam logic [5:0] MinLenRst    = 6'd2;
  localparam logic [5:0] MaxLenRst    = 6'd60;

  // Lengths outside these hard bounds are rejected whatever the registers say.
  localparam logic [7:0] LenFloor     = 8'd2;
  localparam int unsigned LenCeilInt  = 62;

  localparam logic [7:0] RcType       = 8'h16;
  localparam logic [5:0] RcMinLen     = 6'd24;
  localparam logic [7:0] CrcPoly      = 8'hD5;

  localparam int unsigned NumCh       = 8;
  localparam int unsigned ChW         = 11;
  localparam int unsigned ShadowBytes = 11;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [1:0] {
    CFG_SYNC_A  = 2'd0,
    CFG_SYNC_B  = 2'd1,
    CFG_MIN_LEN = 2'd2,
    CFG_MAX_LEN = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CHAN_UPD   = 2'd0,
    ST_GOOD_OTHER = 2'd1,
    ST_CRC_BAD    = 2'd2,
    ST_LEN_REJ    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] sync_a;
    logic [7:0] sync_b;
    logic [5:0] min_len;
    logic [5:0] max_len;
  } cfg_t;

  // One finished or rejected frame on its way from the parser to the back end.
  typedef struct packed {
    status_e                      status;
    logic [7:0]                   addr;
    logic [7:0]                   ftype;
    logic                         upd;
    logic [ShadowBytes*8-1:0]     payload;
  } ev_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  // CRC-8, MSB first, one byte per call.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = (v << 1) ^ CrcPoly;
      end else begin
        v = v << 1;
      end
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/rclfr_front.sv =====
// Parser front end: hunts for sync, checks the length, runs the CRC and captures fields.
// Pushes one event per finished or rejected frame into the result queue. Uses rclfr_pkg.
module rclfr_front import rclfr_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] rx_data_i,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output ev_t        ev_o
);

  localparam int unsigned LenCapInt =
    (MaxFrameBytes - 2 < LenCeilInt) ? MaxFrameBytes - 2 : LenCeilInt;
  localparam logic [7:0] LenCap = 8'(LenCapInt);
  localparam int unsigned ShIdxW = $clog2(ShadowBytes);

  logic [5:0] pos_q, pos_d;
  logic [6:0] total_q, total_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] addr_q, addr_d;
  logic [5:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [ShadowBytes-1:0][7:0] shadow_q, shadow_d;

  logic       accept;
  logic [7:0] hi_len;
  logic [5:0] k;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign hi_len     = ({2'b00, cfg_i.max_len} < LenCap) ? {2'b00, cfg_i.max_len} : LenCap;
  assign k          = pos_q - 6'd3;

  always_comb begin
    pos_d    = pos_q;
    total_d  = total_q;
    crc_d    = crc_q;
    addr_d   = addr_q;
    len_d    = len_q;
    type_d   = type_q;
    shadow_d = shadow_q;
    push_o   = 1'b0;
    ev_o.status  = ST_LEN_REJ;
    ev_o.addr    = addr_q;
    ev_o.ftype   = 8'h00;
    ev_o.upd     = 1'b0;
    ev_o.payload = shadow_q;

    if (accept) begin
      if (action_i) begin
        pos_d   = '0;
        total_d = '0;
      end else if (pos_q == 6'd0) begin
        if (rx_data_i == cfg_i.sync_a || rx_data_i == cfg_i.sync_b) begin
          addr_d = rx_data_i;
          pos_d  = 6'd1;
        end
      end else if (pos_q == 6'd1) begin
        if (rx_data_i < LenFloor || rx_data_i < {2'b00, cfg_i.min_len} || rx_data_i > hi_len) begin
          pos_d   = '0;
          total_d = '0;
          push_o  = 1'b1;
        end else begin
          len_d   = rx_data_i[5:0];
          total_d = 7'd2 + {1'b0, rx_data_i[5:0]};
          crc_d   = '0;
          pos_d   = 6'd2;
        end
      end else if ({1'b0, pos_q} + 7'd1 < total_q) begin
        if (pos_q == 6'd2) begin
          type_d = rx_data_i;
        end else if (k < 6'(ShadowBytes)) begin
          shadow_d[k[ShIdxW-1:0]] = rx_data_i;
        end
        crc_d = crc8_byte(crc_q, rx_data_i);
        pos_d = pos_q + 6'd1;
      end else begin
        // Last byte of the frame carries the CRC.
        push_o     = 1'b1;
        ev_o.ftype = type_q;
        if (crc_q == rx_data_i) begin
          if (type_q == RcType && len_q >= RcMinLen) begin
            ev_o.status = ST_CHAN_UPD;
            ev_o.upd    = 1'b1;
          end else begin
            ev_o.status = ST_GOOD_OTHER;
          end
        end else begin
          ev_o.status = ST_CRC_BAD;
        end
        pos_d   = '0;
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      total_q <= '0;
      crc_q   <= '0;
      addr_q  <= '0;
      len_q   <= '0;
      type_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      total_q <= total_d;
      crc_q   <= crc_d;
      addr_q  <= addr_d;
      len_q   <= len_d;
      type_q  <= type_d;
    end
  end

  // Payload bytes are only read after a full channel frame has rewritten them.
  always_ff @(posedge clk_i) begin
    shadow_q <= shadow_d;
  end

endmodule

// ===== hw/rtl/rclfr_queue.sv =====
// Short FIFO of frame events between the parser front end and the back end.
// Register based; depth comes from rclfr_pkg.
module rclfr_queue import rclfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  ev_t     ev_i,
  input  logic    pop_i,
  output ev_t     ev_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  ev_t [QueueDepth-1:0] mem_q;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full     = (cnt_q == CntW'(QueueDepth));
  assign stat_o.nonempty = (cnt_q != '0);
  assign ev_o            = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ev_i;
    end
  end

endmodule

// ===== hw/rtl/rclfr_back.sv =====
// Back end: applies frame events to the held channel registers and drives the result register.
// Takes events from rclfr_queue. Uses rclfr_pkg.
module rclfr_back import rclfr_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ev_t                       ev_i,
  input  q_stat_t                   q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output status_e                   status_o,
  output logic [7:0]                frame_addr_o,
  output logic [7:0]                frame_type_o,
  output logic [NumCh-1:0][ChW-1:0] chan_o
);

  logic [NumCh-1:0][ChW-1:0] chan_q, chan_d;
  logic out_valid_q;
  status_e status_q;
  logic [7:0] addr_q, type_q;
  logic [NumCh-1:0][ChW-1:0] out_chan_q;

  // The result register is free when empty or when its transfer completes now.
  assign pop_o = q_stat_i.nonempty && (!out_valid_q || !out_stall_i);

  always_comb begin
    chan_d = chan_q;
    if (pop_o && ev_i.upd) begin
      for (int i = 0; i < NumCh; i++) begin
        chan_d[i] = ev_i.payload[i*ChW +: ChW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chan_q <= chan_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q   <= ev_i.status;
      addr_q     <= ev_i.addr;
      type_q     <= ev_i.ftype;
      out_chan_q <= chan_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign frame_addr_o = addr_q;
  assign frame_type_o = type_q;
  assign chan_o       = out_chan_q;

endmodule

// ===== hw/rtl/rc_link_frame_receiver_core.sv =====
// Top level of the RC link frame receiver: configuration registers, front end, queue, back end.
// Depends on rclfr_pkg, rclfr_front, rclfr_queue and rclfr_back.

// The receiver takes one received byte or line-error event per clock cycle unless stalled and
// reports every completed or length-rejected frame as one result carrying its status, address,
// type and the eight held channel values after that frame. The parser front end does the CRC and
// field capture as each byte is taken, so items flow back to back at one per cycle. Finished
// frames go through a two-entry event queue to a registered result stage; the input is stalled
// only while that queue is full, which happens only when the output side holds off results.
// Channel registers reset to zero; configuration must be written while no frame is in flight.
module rc_link_frame_receiver_core import rclfr_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  rx_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  frame_addr_o,
  output logic [7:0]  frame_type_o,
  output logic [10:0] chan0_o,
  output logic [10:0] chan1_o,
  output logic [10:0] chan2_o,
  output logic [10:0] chan3_o,
  output logic [10:0] chan4_o,
  output logic [10:0] chan5_o,
  output logic [10:0] chan6_o,
  output logic [10:0] chan7_o
);

  cfg_t    cfg_q;
  logic    q_push, q_pop;
  ev_t     ev_in, ev_out;
  q_stat_t q_stat;
  status_e status;
  logic [NumCh-1:0][ChW-1:0] chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_a  <= SyncAddrARst;
      cfg_q.sync_b  <= SyncAddrBRst;
      cfg_q.min_len <= MinLenRst;
      cfg_q.max_len <= MaxLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_A:  cfg_q.sync_a  <= cfg_wdata_i;
        CFG_SYNC_B:  cfg_q.sync_b  <= cfg_wdata_i;
        CFG_MIN_LEN: cfg_q.min_len <= cfg_wdata_i[5:0];
        CFG_MAX_LEN: cfg_q.max_len <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  rclfr_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .rx_data_i,
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .ev_o       (ev_in)
  );

  rclfr_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (q_push),
    .ev_i   (ev_in),
    .pop_i  (q_pop),
    .ev_o   (ev_out),
    .stat_o (q_stat)
  );

  rclfr_back u_back (
    .clk_i,
    .rst_ni,
    .ev_i         (ev_out),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .out_valid_o,
    .out_stall_i,
    .status_o     (status),
    .frame_addr_o,
    .frame_type_o,
    .chan_o       (chan)
  );

  assign status_o = status;
  assign chan0_o  = chan[0];
  assign chan1_o  = chan[1];
  assign chan2_o  = chan[2];
  assign chan3_o  = chan[3];
  assign chan4_o  = chan[4];
  assign chan5_o  = chan[5];
  assign chan6_o  = chan[6];
  assign chan7_o  = chan[7];

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("event pushed into full queue");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.nonempty)
    else $error("event popped from empty queue");

  // A rejected length never reports a type byte.
  a_rej_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == ST_LEN_REJ) |-> (frame_type_o == 8'h00))
    else $error("length reject carries nonzero type");

endmodule

// ===== dv/rc_link_frame_receiver_core_tb.sv =====
// Self-checking testbench for rc_link_frame_receiver_core: directed bytes, then random frames.
// Depends on rclfr_pkg and the receiver RTL; holds its own frame parser to predict results.
`timescale 1ns / 1ps

module rc_link_frame_receiver_core_tb import rclfr_pkg::*;;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned LenHardCeil = 62;
  localparam int unsigned ShadowLen   = 11;
  localparam logic [7:0]  ChanFrameType = 8'h16;
  localparam int unsigned ChanFrameMinLen = 24;
  localparam logic [7:0]  Crc8Poly    = 8'hD5;

  typedef struct packed {
    status_e     status;
    logic [7:0]  addr;
    logic [7:0]  ftype;
    logic [87:0] chans;
  } frame_report_t;

  typedef struct {
    logic       act;
    logic [7:0] data;
    logic       typed;
    status_e    st;
    logic [7:0] addr;
    logic [7:0] ftype;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = 2'b00;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        action_i    = 1'b0;
  logic [7:0]  rx_data_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  frame_addr_o;
  logic [7:0]  frame_type_o;
  logic [10:0] chan0_o, chan1_o, chan2_o, chan3_o, chan4_o, chan5_o, chan6_o, chan7_o;
  logic [87:0] chan_bus;

  assign chan_bus = {chan7_o, chan6_o, chan5_o, chan4_o, chan3_o, chan2_o, chan1_o, chan0_o};

  rc_link_frame_receiver_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .rx_data_i    (rx_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .frame_addr_o (frame_addr_o),
    .frame_type_o (frame_type_o),
    .chan0_o      (chan0_o),
    .chan1_o      (chan1_o),
    .chan2_o      (chan2_o),
    .chan3_o      (chan3_o),
    .chan4_o      (chan4_o),
    .chan5_o      (chan5_o),
    .chan6_o      (chan6_o),
    .chan7_o      (chan7_o)
  );

  // Predictor state and its copy of the configuration registers.
  logic [7:0]  cfg_sync_a  = SyncAddrARst;
  logic [7:0]  cfg_sync_b  = SyncAddrBRst;
  logic [5:0]  cfg_min_len = MinLenRst;
  logic [5:0]  cfg_max_len = MaxLenRst;
  int unsigned rx_pos      = 0;
  int unsigned rx_total    = 0;
  logic [7:0]  crc_acc     = 8'h00;
  logic [7:0]  addr_seen   = 8'h00;
  logic [5:0]  len_seen    = 6'd0;
  logic [7:0]  type_seen   = 8'h00;
  logic [87:0] shadow_bits = '0;
  logic [87:0] held_chans  = '0;

  frame_report_t pending_reports[$];
  frame_report_t last_report;
  int unsigned   predicted_n = 0;
  int unsigned   err_count   = 0;
  int unsigned   cycle_cnt   = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   sink_pct     = 0;
  int unsigned   hold_reqs    = 0;
  int unsigned   hold_dones   = 0;
  int unsigned   hold_cnt     = 0;
  bit            in_take      = 1'b0;
  bit            out_take     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[rc_link_frame_receiver_core] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_dones) begin
      out_stall_i <= 1'b1;
      if (hold_cnt == HoldCycles - 1) begin
        hold_cnt   <= 0;
        hold_dones <= hold_dones + 1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_pct);
    end
  end

  function automatic logic [7:0] crc_d5(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] r;
    r = {1'b0, acc ^ b};
    repeat (8) begin
      r = r << 1;
      if (r[8]) begin
        r[7:0] = r[7:0] ^ Crc8Poly;
      end
      r[8] = 1'b0;
    end
    return r[7:0];
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
    err_count++;
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic log_report(input status_e st, input logic [7:0] ftype);
    frame_report_t rep;
    rep.status = st;
    rep.addr   = addr_seen;
    rep.ftype  = ftype;
    rep.chans  = held_chans;
    pending_reports.push_back(rep);
    last_report = rep;
    predicted_n++;
  endtask

  // One received byte or line-error event through the frame parser.
  task automatic parse_rx_byte(input logic act, input logic [7:0] b);
    int unsigned ceil_len;
    status_e     st;
    if (act) begin
      rx_pos   = 0;
      rx_total = 0;
    end else if (rx_pos == 0) begin
      if (b == cfg_sync_a || b == cfg_sync_b) begin
        addr_seen = b;
        rx_pos    = 1;
      end
    end else if (rx_pos == 1) begin
      ceil_len = (cfg_max_len > LenHardCeil) ? LenHardCeil : cfg_max_len;
      if (b < 2 || b < cfg_min_len || b > ceil_len) begin
        rx_pos   = 0;
        rx_total = 0;
        log_report(ST_LEN_REJ, 8'h00);
      end else begin
        len_seen = b[5:0];
        rx_total = 2 + len_seen;
        crc_acc  = 8'h00;
        rx_pos   = 2;
      end
    end else if (rx_pos + 1 < rx_total) begin
      if (rx_pos == 2) begin
        type_seen = b;
      end else if (rx_pos - 3 < ShadowLen) begin
        shadow_bits[(rx_pos - 3) * 8 +: 8] = b;
      end
      crc_acc = crc_d5(crc_acc, b);
      rx_pos  = (rx_pos + 1) % 64;
    end else begin
      // The last byte carries the CRC. Channels pack LSB first, so the shadow bytes
      // already hold the eight 11-bit values in order.
      if (crc_acc == b) begin
        if (type_seen == ChanFrameType && len_seen >= ChanFrameMinLen) begin
          held_chans = shadow_bits;
          st = ST_CHAN_UPD;
        end else begin
          st = ST_GOOD_OTHER;
        end
      end else begin
        st = ST_CRC_BAD;
      end
      rx_pos   = 0;
      rx_total = 0;
      log_report(st, type_seen);
    end
  endtask

  task automatic compare_frame_report();
    frame_report_t want;
    if (pending_reports.size() == 0) begin
      flag_mismatch("result with nothing expected, status", status_o, 0);
    end else begin
      want = pending_reports.pop_front();
      if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
      if (frame_addr_o !== want.addr) flag_mismatch("frame_addr", frame_addr_o, want.addr);
      if (frame_type_o !== want.ftype) flag_mismatch("frame_type", frame_type_o, want.ftype);
      for (int ch = 0; ch < 8; ch++) begin
        if (chan_bus[ch * 11 +: 11] !== want.chans[ch * 11 +: 11]) begin
          flag_mismatch($sformatf("chan%0d", ch), chan_bus[ch * 11 +: 11],
                        want.chans[ch * 11 +: 11]);
        end
      end
    end
  endtask

  // Everything is settled at the falling edge, so the values seen here are the ones the
  // next rising edge acts on.
  always @(negedge clk_i) begin
    in_take  = rst_ni && in_valid_i && !in_stall_o;
    out_take = rst_ni && out_valid_o && !out_stall_i;
    if (out_take) compare_frame_report();
    if (in_take) parse_rx_byte(action_i, rx_data_i);
  end

  task automatic push_item(input logic act, input logic [7:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_data_i  <= data;
    do @(posedge clk_i); while (!in_take);
  endtask

  task automatic wait_drain();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_SYNC_A:  cfg_sync_a  = val;
      CFG_SYNC_B:  cfg_sync_b  = val;
      CFG_MIN_LEN: cfg_min_len = val[5:0];
      default:     cfg_max_len = val[5:0];
    endcase
  endtask

  // Builds one frame around the current settings: mostly accepted lengths with random
  // content, some channel frames, some bad CRCs, a few rejected lengths and cut frames.
  task automatic send_random_frame(output int unsigned n_sent);
    int unsigned lo, hi, lo_rc, len, roll, cut;
    logic [7:0]  crc, ftype, data, len_byte;
    logic [8:0]  fb[$];
    lo   = (cfg_min_len < 2) ? 2 : cfg_min_len;
    hi   = (cfg_max_len > LenHardCeil) ? LenHardCeil : cfg_max_len;
    roll = $urandom_range(99);
    fb.push_back({1'b0, ($urandom_range(1) == 1) ? cfg_sync_a : cfg_sync_b});
    if (roll < 10 || lo > hi) begin
      case ($urandom_range(5))
        0:       len = $urandom_range(1);
        1:       len = lo - 1;
        2:       len = hi + 1;
        3:       len = 63;
        4:       len = $urandom_range(255, 64);
        default: len = $urandom_range(255);
      endcase
      len_byte = len[7:0];
      fb.push_back({1'b0, len_byte});
    end else begin
      if (roll < 45 && hi >= ChanFrameMinLen) begin
        lo_rc = (lo > ChanFrameMinLen) ? lo : ChanFrameMinLen;
        len   = ($urandom_range(9) == 0) ? $urandom_range(hi, lo_rc)
                                         : lo_rc + $urandom_range((hi - lo_rc < 4) ? hi - lo_rc : 4);
        ftype = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ChanFrameType;
      end else begin
        len   = ($urandom_range(9) == 0) ? $urandom_range(hi, lo)
                                         : lo + $urandom_range((hi - lo < 6) ? hi - lo : 6);
        ftype = ($urandom_range(4) == 0) ? ChanFrameType : 8'($urandom_range(255));
      end
      len_byte = len[7:0];
      fb.push_back({1'b0, len_byte});
      fb.push_back({1'b0, ftype});
      crc = crc_d5(8'h00, ftype);
      for (int i = 0; i < len - 2; i++) begin
        data = 8'($urandom_range(255));
        fb.push_back({1'b0, data});
        crc = crc_d5(crc, data);
      end
      if ($urandom_range(6) == 0) crc = crc ^ 8'($urandom_range(255, 1));
      fb.push_back({1'b0, crc});
      if ($urandom_range(19) == 0) begin
        cut = $urandom_range(fb.size() - 1, 1);
        while (fb.size() > cut) void'(fb.pop_back());
        data = 8'($urandom_range(255));
        fb.push_back({1'b1, data});
      end
    end
    foreach (fb[i]) push_item(fb[i][8], fb[i][7:0]);
    n_sent = fb.size();
  endtask

  task automatic run_phase(input logic [7:0] sync_a, input logic [7:0] sync_b,
                           input logic [7:0] min_len, input logic [7:0] max_len,
                           input int unsigned src_pct, input int unsigned stall_pct,
                           input int unsigned n_items, input bit with_hold, input bit with_pause);
    int unsigned sent, n_frame, n_noise;
    bit          held, paused;
    logic [7:0]  noise;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    write_cfg(CFG_SYNC_A, sync_a);
    write_cfg(CFG_SYNC_B, sync_b);
    write_cfg(CFG_MIN_LEN, min_len);
    write_cfg(CFG_MAX_LEN, max_len);
    cfg_we_i     <= 1'b0;
    src_idle_pct  = src_pct;
    sink_pct     <= stall_pct;
    while (sent < n_items) begin
      if (with_hold && !held && sent >= n_items / 3) begin
        hold_reqs <= hold_reqs + 1;
        held = 1'b1;
      end
      if (with_pause && !paused && sent >= n_items / 2) begin
        // Sender goes quiet until every outstanding result has come back.
        in_valid_i <= 1'b0;
        wait_drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 8) begin
        n_noise = $urandom_range(3, 1);
        repeat (n_noise) begin
          noise = 8'($urandom_range(255));
          push_item(1'b0, noise);
        end
      end
      if ($urandom_range(99) < 3) begin
        noise = 8'($urandom_range(255));
        push_item(1'b1, noise);
      end
      send_random_frame(n_frame);
      sent += n_frame;
    end
    // A line error leaves the parser hunting before the settings change.
    push_item(1'b1, 8'h00);
    in_valid_i <= 1'b0;
    wait_drain();
  endtask

  stim_row_t   dir_rows [24];
  int unsigned seen_before;

  initial begin
    dir_rows = '{
      '{1'b0, 8'h00, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b1, 8'hFF, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'hC8, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h01, 1'b1, ST_LEN_REJ,    8'hC8, 8'h00},
      '{1'b0, 8'hEA, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h00, 1'b1, ST_LEN_REJ,    8'hEA, 8'h00},
      '{1'b0, 8'hC8, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h3D, 1'b1, ST_LEN_REJ,    8'hC8, 8'h00},
      '{1'b0, 8'hEA, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'hFF, 1'b1, ST_LEN_REJ,    8'hEA, 8'h00},
      '{1'b0, 8'hC8, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'hC8, 1'b1, ST_LEN_REJ,    8'hC8, 8'h00},
      '{1'b0, 8'h02, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'hEA, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h02, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h00, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h00, 1'b1, ST_GOOD_OTHER, 8'hEA, 8'h00},
      '{1'b0, 8'hC8, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h3C, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b1, 8'h00, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'hC8, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h02, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h16, 1'b0, ST_CHAN_UPD,   8'h00, 8'h00},
      '{1'b0, 8'h00, 1'b1, ST_CRC_BAD,    8'hC8, 8'h16}
    };
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes against the reset settings; typed rows also pin the predictor down.
    foreach (dir_rows[r]) begin
      seen_before = predicted_n;
      push_item(dir_rows[r].act, dir_rows[r].data);
      if (dir_rows[r].typed) begin
        if (predicted_n == seen_before) begin
          flag_mismatch($sformatf("directed row %0d produced no result", r), 0, 1);
        end else begin
          if (last_report.status != dir_rows[r].st) begin
            flag_mismatch("directed status", last_report.status, dir_rows[r].st);
          end
          if (last_report.addr != dir_rows[r].addr) begin
            flag_mismatch("directed addr", last_report.addr, dir_rows[r].addr);
          end
          if (last_report.ftype != dir_rows[r].ftype) begin
            flag_mismatch("directed type", last_report.ftype, dir_rows[r].ftype);
          end
        end
      end
    end
    in_valid_i <= 1'b0;
    wait_drain();

    run_phase(8'hC8, 8'hEA, 8'd2,  8'd62, 0,  0,  230, 1'b0, 1'b1);
    run_phase(8'h00, 8'hFF, 8'd2,  8'd62, 55, 0,  230, 1'b0, 1'b0);
    run_phase(8'h5A, 8'h5A, 8'd24, 8'd30, 0,  55, 230, 1'b0, 1'b0);
    run_phase(8'hC8, 8'hEA, 8'd62, 8'd62, 29, 29, 180, 1'b0, 1'b0);
    run_phase(8'hC8, 8'hEA, 8'd40, 8'd10, 29, 29, 90,  1'b0, 1'b0);
    run_phase(8'hEA, 8'hC8, 8'd2,  8'd2,  0,  0,  180, 1'b1, 1'b0);
    run_phase(8'hC8, 8'hEA, 8'd2,  8'd60, 55, 55, 230, 1'b1, 1'b1);

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[rc_link_frame_receiver_core] OK");
    end else begin
      $display("[rc_link_frame_receiver_core] ERROR");
    end
    $finish;
  end

endmodule
